FILE: design/bia_pkg.sv
`timescale 1ns / 1ps

package bia_pkg;

    localparam int ID_W     = 11;
    localparam int GID_W    = 10;
    localparam int STAT_W   = 2;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;
    localparam int IDWORD_W = ID_W - BIT_W;

    localparam logic [WORD_W-1:0] WORD_ALL_FREE = 32'hFFFF_FFFF;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_GRANTED   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NONE_FREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FREED     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              zero;
        logic [BIT_W-1:0]  idx;
        logic [WORD_W-1:0] cleared;
    } lsb_t;

endpackage

FILE: design/bia_map_ram.sv
`timescale 1ns / 1ps

module bia_map_ram
    import bia_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/bia_lsb_find.sv
`timescale 1ns / 1ps

module bia_lsb_find
    import bia_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    output lsb_t              res
);

    logic [WORD_W-1:0] low_bit;
    logic [BIT_W-1:0]  idx;

    // isolate the lowest set bit, then encode the one-hot result
    assign low_bit = word & (~word + WORD_W'(1));

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (low_bit[i])
            begin
                idx = idx | BIT_W'(i);
            end
        end
    end

    assign res.zero    = (word == '0);
    assign res.idx     = idx;
    assign res.cleared = word & (word - WORD_W'(1));

endmodule

FILE: design/bitmap_id_allocator_core.sv
`timescale 1ns / 1ps

// first-free id allocator; a free reads then writes its map word, an out-of-range
// free goes straight to the result, and an allocate runs a word scan that tests one
// registered ram word per cycle
// one item in flight: a new item is accepted once the last result is registered, even while it waits
// reset (rst_n low, asynchronous) clears control; then a clearing pass
// writes every word to all free before the first item is accepted
module bitmap_id_allocator_core
    import bia_pkg::*;
#(
    parameter int ID_COUNT = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] id_to_free, rest zero
    input  logic [0:0]  s_tuser,   // [0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] granted_id, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int MAP_WORDS = ID_COUNT / WORD_W;
    localparam int AW        = $clog2(MAP_WORDS);
    localparam int PTR_W     = AW + 1;
    localparam int FULL_W    = AW + BIT_W;

    state_t state_reg, state_next;

    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [AW-1:0]     chk_addr_reg, chk_addr_next;
    logic [ID_W-1:0]   req_id_reg, req_id_next;
    logic [GID_W-1:0]  res_id_reg, res_id_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;
    logic              out_valid_reg, out_valid_next;
    logic [GID_W-1:0]  out_id_reg, out_id_next;
    logic [STAT_W-1:0] out_stat_reg, out_stat_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    lsb_t              lsb;

    logic              in_accept;
    logic              in_range;
    logic              issue_ok;
    logic              last_chk;
    logic              clear_last;
    logic              out_free;
    logic [FULL_W-1:0] full_id;

    bia_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bia_lsb_find u_lsb (
        .word (ram_rdata),
        .res  (lsb)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_range  = ({{(32 - IDWORD_W){1'b0}}, s_tdata[ID_W-1:BIT_W]} < 32'(MAP_WORDS));
    assign issue_ok  = (ptr_reg < PTR_W'(MAP_WORDS));
    assign last_chk  = (chk_addr_reg == AW'(MAP_WORDS - 1));
    assign clear_last = (ptr_reg == PTR_W'(MAP_WORDS - 1));
    assign out_free  = !out_valid_reg || m_tready;
    assign full_id   = {chk_addr_reg, lsb.idx};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser[0] == REQ_ALLOC)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (in_range)
                    begin
                        state_next = ST_FREE_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (chk_valid_reg && (!lsb.zero || last_chk))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FREE_RD:
            begin
                state_next = ST_FREE_WR;
            end
            ST_FREE_WR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        ptr_next       = ptr_reg;
        chk_valid_next = 1'b0;
        chk_addr_next  = chk_addr_reg;
        req_id_next    = req_id_reg;
        res_id_next    = res_id_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_stat_next  = out_stat_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg[AW-1:0];
        ram_wdata      = WORD_ALL_FREE;
        ram_re         = 1'b0;
        ram_raddr      = ptr_reg[AW-1:0];

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ptr_next = clear_last ? '0 : ptr_reg + PTR_W'(1);
            end
            ST_IDLE:
            begin
                ptr_next = '0;
                if (in_accept)
                begin
                    req_id_next = s_tdata[ID_W-1:0];
                    res_id_next = '0;
                    if (s_tuser[0] == REQ_FREE && !in_range)
                    begin
                        res_stat_next = STAT_RANGE;
                    end
                end
            end
            ST_SCAN:
            begin
                // reads run one word ahead of the test on the registered data
                if (issue_ok)
                begin
                    ram_re         = 1'b1;
                    ptr_next       = ptr_reg + PTR_W'(1);
                    chk_valid_next = 1'b1;
                    chk_addr_next  = ptr_reg[AW-1:0];
                end
                if (chk_valid_reg)
                begin
                    if (!lsb.zero)
                    begin
                        ram_we        = 1'b1;
                        ram_waddr     = chk_addr_reg;
                        ram_wdata     = lsb.cleared;
                        res_id_next   = GID_W'(full_id);
                        res_stat_next = STAT_GRANTED;
                    end
                    else if (last_chk)
                    begin
                        res_id_next   = '0;
                        res_stat_next = STAT_NONE_FREE;
                    end
                end
            end
            ST_FREE_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = AW'(req_id_reg[ID_W-1:BIT_W]);
            end
            ST_FREE_WR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = AW'(req_id_reg[ID_W-1:BIT_W]);
                ram_wdata     = ram_rdata | (WORD_W'(1) << req_id_reg[BIT_W-1:0]);
                res_stat_next = STAT_FREED;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = res_id_reg;
                    out_stat_next  = res_stat_reg;
                end
            end
            default:
            begin
                ptr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg <= chk_addr_next;
        req_id_reg   <= req_id_next;
        res_id_reg   <= res_id_next;
        res_stat_reg <= res_stat_next;
        out_id_reg   <= out_id_next;
        out_stat_reg <= out_stat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - GID_W){1'b0}}, out_id_reg};
    assign m_tuser  = out_stat_reg;

endmodule
